@@ sv/asd_pkg.sv @@
// Shared types and constants of the SGR stream decoder.
package asd_pkg;

  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_CSI  = 8'h5B;
  localparam logic [7:0] BYTE_M    = 8'h6D;
  localparam logic [7:0] BYTE_SEMI = 8'h3B;
  localparam logic [7:0] BYTE_D0   = 8'h30;
  localparam logic [7:0] BYTE_D9   = 8'h39;

  localparam logic [15:0] NUM_MAX = 16'hFFFF;

  localparam logic [2:0] KIND_UNSET   = 3'd0;
  localparam logic [2:0] KIND_DEFAULT = 3'd1;
  localparam logic [2:0] KIND_P16     = 3'd2;
  localparam logic [2:0] KIND_P256    = 3'd3;
  localparam logic [2:0] KIND_RGB     = 3'd4;

  localparam logic [15:0] CODE_FG_EXT = 16'd38;
  localparam logic [15:0] CODE_BG_EXT = 16'd48;
  localparam logic [15:0] SUB_RGB     = 16'd2;
  localparam logic [15:0] SUB_P256    = 16'd5;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        span_start;
    logic [2:0]  fg_kind;
    logic [23:0] fg_value;
    logic [2:0]  bg_kind;
    logic [23:0] bg_value;
    logic [8:0]  attr_flags;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] value;
  } colour_t;

  // controller -> datapath
  typedef struct packed {
    logic       take;
    logic       emit2;
    logic [2:0] rd_off;
    logic       apply_code;
    logic       latch_sel;
    logic       latch_r;
    logic       latch_g;
    logic       set_rgb;
    logic       set_p256;
    logic [2:0] i_add;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic e1;
    logic e2;
    logic walk;
    logic idx_end;
    logic has1;
    logic code_ext;
    logic k_rgb;
    logic k_p256;
  } stat_t;

endpackage

@@ sv/asd_stream_if.sv @@
// Valid/ready stream interface carrying one payload struct.
interface asd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/asd_datapath.sv @@
// Datapath: byte decode, code store, style registers and output register.
module asd_datapath #(
  parameter int CODE_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  asd_pkg::in_t  in_data,
  input  asd_pkg::cmd_t cmd,
  output asd_pkg::stat_t stat,
  output asd_pkg::out_t out_data
);

  localparam int AW = (CODE_SLOTS > 1) ? $clog2(CODE_SLOTS) : 1;
  localparam int CW = $clog2(CODE_SLOTS + 1);
  localparam int IW = $clog2(CODE_SLOTS + 5);

  logic [15:0] code_mem [CODE_SLOTS];
  logic [15:0] rd_data_r;

  logic          held_r, inseq_r, dig_r, anyp_r, span_r, sel_fg_r, pend_last_r;
  logic [15:0]   acc_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] n_r, i_r;
  logic [7:0]    red_r, grn_r, pend_char_r;
  asd_pkg::colour_t fg_r, bg_r;
  logic [8:0]    attr_r;
  asd_pkg::out_t out_r;

  logic          held_nxt, inseq_nxt, dig_nxt, anyp_nxt, span_nxt, pend_last_nxt;
  logic [15:0]   acc_nxt;
  logic [CW-1:0] cnt_nxt;
  logic [IW-1:0] n_nxt, i_nxt;
  asd_pkg::colour_t fg_nxt, bg_nxt;
  logic [8:0]    attr_nxt;

  // byte decode
  logic [7:0] b;
  logic last, is_esc, is_csi, is_m, is_semi, is_digit, plain_emit;
  assign b        = in_data.text_byte;
  assign last     = in_data.end_of_text;
  assign is_esc   = (b == asd_pkg::BYTE_ESC);
  assign is_csi   = (b == asd_pkg::BYTE_CSI);
  assign is_m     = (b == asd_pkg::BYTE_M);
  assign is_semi  = (b == asd_pkg::BYTE_SEMI);
  assign is_digit = (b >= asd_pkg::BYTE_D0) && (b <= asd_pkg::BYTE_D9);
  assign plain_emit = !(is_esc && !last);

  logic e1, e1_esc, e2, walk;
  always_comb begin
    e1 = 1'b0; e1_esc = 1'b0; e2 = 1'b0; walk = 1'b0;
    if (held_r) begin
      if (!is_csi) begin
        e1 = 1'b1; e1_esc = 1'b1; e2 = plain_emit;
      end
    end else if (inseq_r) begin
      if (is_m) walk = !last;
      else if (!is_digit && !is_semi) e1 = plain_emit;
    end else begin
      e1 = plain_emit;
    end
  end

  // saturating decimal accumulate
  logic [19:0] acc_wide;
  logic [15:0] acc_sat;
  assign acc_wide = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'd0, b[3:0]};
  assign acc_sat  = (acc_wide > {4'd0, asd_pkg::NUM_MAX}) ? asd_pkg::NUM_MAX : acc_wide[15:0];

  // code push
  logic          push, push_ok;
  logic [15:0]   push_val;
  logic [CW-1:0] cnt_push;
  assign push     = inseq_r && !held_r && (is_semi || (is_m && (dig_r || !anyp_r)));
  assign push_val = dig_r ? acc_r : 16'd0;
  assign push_ok  = push && (cnt_r < CW'(CODE_SLOTS));
  assign cnt_push = push_ok ? cnt_r + CW'(1) : cnt_r;

  // walk status
  logic [IW-1:0] rd_idx;
  assign rd_idx = i_r + IW'(cmd.rd_off);
  assign stat.e1       = e1;
  assign stat.e2       = e2;
  assign stat.walk     = walk;
  assign stat.idx_end  = (i_r >= n_r);
  assign stat.has1     = (i_r + IW'(1)) < n_r;
  assign stat.code_ext = (rd_data_r == asd_pkg::CODE_FG_EXT) ||
                         (rd_data_r == asd_pkg::CODE_BG_EXT);
  assign stat.k_rgb    = (rd_data_r == asd_pkg::SUB_RGB) && ((i_r + IW'(4)) < n_r);
  assign stat.k_p256   = (rd_data_r == asd_pkg::SUB_P256) && ((i_r + IW'(2)) < n_r);

  // code store
  always_ff @(posedge clk) begin
    if (cmd.take && push_ok) code_mem[cnt_r[AW-1:0]] <= push_val;
    rd_data_r <= code_mem[rd_idx[AW-1:0]];
  end

  // output register and walk operands
  always_ff @(posedge clk) begin
    if (cmd.take && e1) begin
      out_r.out_char    <= e1_esc ? asd_pkg::BYTE_ESC : b;
      out_r.span_start  <= span_r;
      out_r.fg_kind     <= fg_r.kind;
      out_r.fg_value    <= fg_r.value;
      out_r.bg_kind     <= bg_r.kind;
      out_r.bg_value    <= bg_r.value;
      out_r.attr_flags  <= attr_r;
      out_r.last_of_run <= !e2;
    end else if (cmd.emit2) begin
      out_r.out_char    <= pend_char_r;
      out_r.span_start  <= span_r;
      out_r.fg_kind     <= fg_r.kind;
      out_r.fg_value    <= fg_r.value;
      out_r.bg_kind     <= bg_r.kind;
      out_r.bg_value    <= bg_r.value;
      out_r.attr_flags  <= attr_r;
      out_r.last_of_run <= 1'b1;
    end
    if (cmd.take) pend_char_r <= b;
    if (cmd.latch_sel) sel_fg_r <= (rd_data_r == asd_pkg::CODE_FG_EXT);
    if (cmd.latch_r) red_r <= rd_data_r[7:0];
    if (cmd.latch_g) grn_r <= rd_data_r[7:0];
  end
  assign out_data = out_r;

  // parser and style next state
  logic clr_all;
  assign clr_all = (cmd.take && last && !e2) || (cmd.emit2 && pend_last_r);

  always_comb begin
    held_nxt = held_r; inseq_nxt = inseq_r; acc_nxt = acc_r; dig_nxt = dig_r;
    anyp_nxt = anyp_r; cnt_nxt = cnt_r; n_nxt = n_r; span_nxt = span_r;
    pend_last_nxt = pend_last_r;
    i_nxt = i_r + IW'(cmd.i_add);
    fg_nxt = fg_r; bg_nxt = bg_r; attr_nxt = attr_r;
    if (cmd.take) begin
      pend_last_nxt = last;
      if (held_r) begin
        held_nxt = 1'b0;
        if (is_csi) begin
          inseq_nxt = 1'b1; acc_nxt = '0; dig_nxt = 1'b0; anyp_nxt = 1'b0;
          cnt_nxt = '0; span_nxt = 1'b1;
        end else begin
          span_nxt = 1'b0;
          if (!plain_emit) held_nxt = 1'b1;
        end
      end else if (inseq_r) begin
        if (is_digit) begin
          anyp_nxt = 1'b1; dig_nxt = 1'b1; acc_nxt = acc_sat;
        end else if (is_semi) begin
          anyp_nxt = 1'b1; acc_nxt = '0; dig_nxt = 1'b0; cnt_nxt = cnt_push;
        end else begin
          inseq_nxt = 1'b0; acc_nxt = '0; dig_nxt = 1'b0; anyp_nxt = 1'b0;
          cnt_nxt = '0;
          if (is_m) begin
            n_nxt = IW'(cnt_push);
            i_nxt = '0;
          end else if (plain_emit) begin
            span_nxt = 1'b0;
          end else begin
            held_nxt = 1'b1;
          end
        end
      end else if (plain_emit) begin
        span_nxt = 1'b0;
      end else begin
        held_nxt = 1'b1;
      end
    end
    if (cmd.emit2) span_nxt = 1'b0;

    // code walk
    if (cmd.apply_code) begin
      case (rd_data_r) inside
        16'd0: begin
          fg_nxt = '0; bg_nxt = '0; attr_nxt = '0;
        end
        [16'd1:16'd9]: attr_nxt = attr_r | (9'd1 << (rd_data_r[3:0] - 4'd1));
        16'd21: attr_nxt[3] = 1'b1;
        [16'd30:16'd37]: fg_nxt = '{asd_pkg::KIND_P16, 24'(rd_data_r - 16'd30)};
        [16'd90:16'd97]: fg_nxt = '{asd_pkg::KIND_P16, 24'(rd_data_r - 16'd82)};
        [16'd40:16'd47]: bg_nxt = '{asd_pkg::KIND_P16, 24'(rd_data_r - 16'd40)};
        [16'd100:16'd107]: bg_nxt = '{asd_pkg::KIND_P16, 24'(rd_data_r - 16'd92)};
        16'd39: fg_nxt = '{asd_pkg::KIND_DEFAULT, 24'd0};
        16'd49: bg_nxt = '{asd_pkg::KIND_DEFAULT, 24'd0};
        default: ;
      endcase
    end
    if (cmd.set_rgb) begin
      if (sel_fg_r) fg_nxt = '{asd_pkg::KIND_RGB, {red_r, grn_r, rd_data_r[7:0]}};
      else          bg_nxt = '{asd_pkg::KIND_RGB, {red_r, grn_r, rd_data_r[7:0]}};
    end
    if (cmd.set_p256) begin
      if (sel_fg_r) fg_nxt = '{asd_pkg::KIND_P256, {16'd0, rd_data_r[7:0]}};
      else          bg_nxt = '{asd_pkg::KIND_P256, {16'd0, rd_data_r[7:0]}};
    end

    // end of text: back to reset state
    if (clr_all) begin
      held_nxt = 1'b0; inseq_nxt = 1'b0; acc_nxt = '0; dig_nxt = 1'b0; anyp_nxt = 1'b0;
      cnt_nxt = '0; fg_nxt = '0; bg_nxt = '0; attr_nxt = '0; span_nxt = 1'b1;
    end
  end

  // parser and style registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0; inseq_r <= 1'b0; acc_r <= '0; dig_r <= 1'b0; anyp_r <= 1'b0;
      cnt_r <= '0; n_r <= '0; i_r <= '0; fg_r <= '0; bg_r <= '0; attr_r <= '0;
      span_r <= 1'b1; pend_last_r <= 1'b0;
    end else begin
      held_r <= held_nxt; inseq_r <= inseq_nxt; acc_r <= acc_nxt; dig_r <= dig_nxt;
      anyp_r <= anyp_nxt; cnt_r <= cnt_nxt; n_r <= n_nxt; i_r <= i_nxt;
      fg_r <= fg_nxt; bg_r <= bg_nxt; attr_r <= attr_nxt;
      span_r <= span_nxt; pend_last_r <= pend_last_nxt;
    end
  end

endmodule

@@ sv/asd_ctrl.sv @@
// Controller: request handshakes, second emit and the walk over stored codes.
module asd_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  asd_pkg::stat_t stat,
  output asd_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT2, S_ISSUE, S_CODE, S_SUB, S_RED, S_GRN, S_BLU, S_PAL
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt, free;

  assign free = !out_valid_r || out_ready;

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = free;
        if (in_valid && free) begin
          cmd.take = 1'b1;
          if (stat.e2) state_nxt = S_EMIT2;
          else if (stat.walk) state_nxt = S_ISSUE;
        end
      end
      S_EMIT2: begin
        if (free) begin
          cmd.emit2 = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_ISSUE: state_nxt = stat.idx_end ? S_IDLE : S_CODE;
      S_CODE: begin
        if (!stat.code_ext) begin
          cmd.apply_code = 1'b1; cmd.i_add = 3'd1; state_nxt = S_ISSUE;
        end else if (stat.has1) begin
          cmd.rd_off = 3'd1; cmd.latch_sel = 1'b1; state_nxt = S_SUB;
        end else begin
          cmd.i_add = 3'd1; state_nxt = S_ISSUE;
        end
      end
      S_SUB: begin
        if (stat.k_rgb) begin
          cmd.rd_off = 3'd2; state_nxt = S_RED;
        end else if (stat.k_p256) begin
          cmd.rd_off = 3'd2; state_nxt = S_PAL;
        end else begin
          cmd.i_add = 3'd1; state_nxt = S_ISSUE;
        end
      end
      S_RED: begin
        cmd.latch_r = 1'b1; cmd.rd_off = 3'd3; state_nxt = S_GRN;
      end
      S_GRN: begin
        cmd.latch_g = 1'b1; cmd.rd_off = 3'd4; state_nxt = S_BLU;
      end
      S_BLU: begin
        cmd.set_rgb = 1'b1; cmd.i_add = 3'd5; state_nxt = S_ISSUE;
      end
      S_PAL: begin
        cmd.set_p256 = 1'b1; cmd.i_add = 3'd3; state_nxt = S_ISSUE;
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || (cmd.take && stat.e1) || cmd.emit2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && stat.e2) |=> (state_r == S_EMIT2))
    else $error("second result not scheduled");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ((cmd.take && stat.e1) || cmd.emit2) |=> out_valid_r)
    else $error("emitted result not presented");
  a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("request taken while busy");
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && stat.walk) |=> (state_r == S_ISSUE))
    else $error("code walk not started");

endmodule

@@ sv/ansi_sgr_stream_decoder_core.sv @@
// Top level of the SGR stream decoder: controller plus datapath.
//
//  channel  dir  payload                              handshake
//  in_ch    in   text_byte, end_of_text               valid/ready
//  out_ch   out  out_char, span_start, colours, attrs valid/ready
//
// A byte after a lone ESC gives a second result: the ESC, then the byte.
// On 'm' the stored codes are walked through one memory read port: each plain
// code, 38/48;2;r;g;b group and 38/48;5;n group in turn.
// Synchronous active-low reset; no clearing pass (code store is written first).
// A full output register that is not taken holds off new requests.
module ansi_sgr_stream_decoder_core #(
  parameter int CODE_SLOTS = 16
) (
  input logic clk,
  input logic rst_n,
  asd_stream_if.sink   in_ch,
  asd_stream_if.source out_ch
);

  asd_pkg::cmd_t  cmd;
  asd_pkg::stat_t stat;

  asd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  asd_datapath #(.CODE_SLOTS(CODE_SLOTS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_ch.data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_ch.data)
  );

endmodule
